>>> rtl/lepb_pkg.sv
// ============================================================================
// lepb_pkg : shared types, constants and functions
// Types and helpers for the LED engine program builder: the data word that
// travels down the divider chain and the step time encoding.
// ============================================================================
package lepb_pkg;

    // Request kinds carried on s_tuser
    localparam logic MODE_RAMP  = 1'b0;
    localparam logic MODE_BLINK = 1'b1;

    // Engine instruction words
    localparam logic [15:0] WORD_SET_LEVEL = 16'h4000;
    localparam logic [15:0] WORD_LOOP      = 16'hA081;
    localparam logic [15:0] WORD_END       = 16'hC000;
    localparam logic [15:0] WORD_GO_START  = 16'h0000;

    // Step time encoding
    localparam logic [15:0] STEP_MAX       = 16'h003F;
    localparam int          PRESCALE_SHIFT = 5;          // divide by 32

    // Position of the final word of each program
    localparam logic [2:0]  RAMP_LAST_IDX  = 3'd3;
    localparam logic [2:0]  BLINK_LAST_IDX = 3'd4;

    // Divider geometry: dividend is 2 * ramp_time, one quotient bit per cell
    localparam int DIVIDEND_W = 17;
    localparam int DIV_STAGES = DIVIDEND_W;

    // Request context carried alongside the division
    typedef struct packed {
        logic       mode;
        logic       empty;      // ramp with equal levels: no words
        logic [7:0] level;      // start level or blink level
        logic       down;
        logic [6:0] half;       // half the level difference
        logic [6:0] on_code;    // blink on delay {prescale, step}
        logic [6:0] off_code;   // blink off delay {prescale, step}
    } ctx_t;

    // Payload of one divider cell
    typedef struct packed {
        logic [7:0]            rem;
        logic [DIVIDEND_W-1:0] acc;   // dividend bits out at top, quotient in at bottom
        logic [7:0]            dvs;
        ctx_t                  ctx;
    } cell_data_t;

    // Raw 16-bit step value to {prescale, step[5:0]}
    function automatic logic [6:0] step_code(input logic [15:0] raw);
        logic [15:0] t;
        logic        pre;
        begin
            t   = raw;
            pre = 1'b0;
            if (raw > STEP_MAX)
            begin
                t   = raw >> PRESCALE_SHIFT;
                pre = 1'b1;
            end
            if (t == 16'd0)
                t = 16'd1;
            else if (t > STEP_MAX)
                t = STEP_MAX;
            return {pre, t[5:0]};
        end
    endfunction

    // Timing word from an encoded step
    function automatic logic [15:0] step_word(input logic [6:0] code);
        return {1'b0, code, 8'h00};
    endfunction

endpackage

>>> rtl/led_engine_program_builder.sv
// ============================================================================
// led_engine_program_builder : LED engine program word generator
// Turns one ramp or blink request into the instruction words of a short
// engine program, through a chain of division cells and an output stage.
// ============================================================================
//
//  Channel | Dir | Beat contents
//  --------+-----+----------------------------------------------------------
//  s_*     | in  | one request: levels, times, kind on s_tuser
//  m_*     | out | one program word with its index, m_tlast on final word
//
//  A request passes through the divider chain (one quotient bit per cell) and
//  then the output stage sends one word per cycle unless m_tready stalls it: 4
//  beats for a ramp, 5 for a blink, none for a ramp with equal levels. Sustained
//  rate is set by the output stage, which loads a request as its last word goes.
//  Reset clears all valid flags; the chain freezes as a whole while its last
//  cell holds a request the output stage cannot yet take.
//
module led_engine_program_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [7:0] start_level, [15:8] end_level,
                                   // [31:16] ramp_time, [47:32] on_duration,
                                   // [63:48] blink_period, [71:64] blink_level
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] program_word, [18:16] word_index, zero pad
    output logic        m_tlast
);

    localparam int N = lepb_pkg::DIV_STAGES;

    logic                  cell_valid [0:N];
    lepb_pkg::cell_data_t  cell_data  [0:N];
    logic                  adv;
    logic                  ser_free;

    logic       mode;
    logic [7:0] start_level;
    logic [7:0] end_level;
    logic [15:0] ramp_time;
    logic [15:0] on_duration;
    logic [15:0] blink_period;
    logic [7:0] blink_level;
    logic [7:0] diff;
    logic [15:0] off_time;

    // Field unpack
    assign mode         = s_tuser[0];
    assign start_level  = s_tdata[7:0];
    assign end_level    = s_tdata[15:8];
    assign ramp_time    = s_tdata[31:16];
    assign on_duration  = s_tdata[47:32];
    assign blink_period = s_tdata[63:48];
    assign blink_level  = s_tdata[71:64];

    // Entry: level difference and blink delays
    assign diff     = (end_level > start_level) ? (end_level - start_level)
                                                : (start_level - end_level);
    assign off_time = blink_period - on_duration;

    always_comb
    begin
        cell_data[0].rem          = 8'd0;
        cell_data[0].acc          = {ramp_time, 1'b0};
        cell_data[0].dvs          = diff;
        cell_data[0].ctx.mode     = mode;
        cell_data[0].ctx.empty    = (mode == lepb_pkg::MODE_RAMP)
                                 && (start_level == end_level);
        cell_data[0].ctx.level    = (mode == lepb_pkg::MODE_BLINK) ? blink_level
                                                                   : start_level;
        cell_data[0].ctx.down     = (end_level < start_level);
        cell_data[0].ctx.half     = diff[7:1];
        cell_data[0].ctx.on_code  = lepb_pkg::step_code({on_duration[14:0], 1'b0});
        cell_data[0].ctx.off_code = lepb_pkg::step_code({off_time[14:0], 1'b0});
    end

    assign cell_valid[0] = s_tvalid;

    // Chain advances when its tail is empty or handed off
    assign adv      = !cell_valid[N] || ser_free;
    assign s_tready = adv;

    // Divider chain
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        lepb_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (cell_valid[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    // Output stage
    lepb_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cell_valid[N]),
        .in_data  (cell_data[N]),
        .free     (ser_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/lepb_div_cell.sv
// ============================================================================
// lepb_div_cell : one restoring division step
// Brings in the next dividend bit, subtracts the divisor when it fits and
// shifts the quotient bit in. Passes the request context on unchanged.
// ============================================================================
module lepb_div_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  lepb_pkg::cell_data_t   in_data,
    output logic                   out_valid,
    output lepb_pkg::cell_data_t   out_data
);

    logic                  valid_reg;
    lepb_pkg::cell_data_t  data_reg;
    lepb_pkg::cell_data_t  data_next;
    logic [8:0]            trial;
    logic [8:0]            sub;
    logic                  fits;

    // Partial remainder with next dividend bit, trial subtract
    assign trial = {in_data.rem, in_data.acc[lepb_pkg::DIVIDEND_W-1]};
    assign sub   = trial - {1'b0, in_data.dvs};
    assign fits  = (trial >= {1'b0, in_data.dvs});

    always_comb
    begin
        data_next     = in_data;
        data_next.rem = fits ? sub[7:0] : trial[7:0];
        data_next.acc = {in_data.acc[lepb_pkg::DIVIDEND_W-2:0], fits};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/lepb_serializer.sv
// ============================================================================
// lepb_serializer : program word output stage
// Takes one finished request from the divider chain and sends its program
// words one beat at a time, in order, with index and last flag.
// ============================================================================
module lepb_serializer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  lepb_pkg::cell_data_t   in_data,
    output logic                   free,       // may take a request this cycle
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,    // [15:0] program_word, [18:16] word_index
    output logic                   m_tlast
);

    logic        valid_reg;
    logic [2:0]  idx_reg;
    logic        mode_reg;
    logic [7:0]  level_reg;
    logic [15:0] word1_reg;
    logic [15:0] word3_reg;
    logic [15:0] word1_next;
    logic [15:0] word3_next;
    logic [2:0]  last_idx;
    logic        is_last;
    logic        load;
    logic [15:0] word;
    logic [6:0]  ramp_code;

    // Word 1 and word 3 as built at load time
    assign ramp_code = lepb_pkg::step_code(in_data.acc[15:0]);

    always_comb
    begin
        if (in_data.ctx.mode == lepb_pkg::MODE_BLINK)
        begin
            word1_next = lepb_pkg::step_word(in_data.ctx.on_code);
            word3_next = lepb_pkg::step_word(in_data.ctx.off_code);
        end
        else
        begin
            word1_next = lepb_pkg::step_word(ramp_code)
                       | {8'h00, in_data.ctx.down, in_data.ctx.half};
            word3_next = lepb_pkg::WORD_END;
        end
    end

    // Beat bookkeeping
    assign last_idx = (mode_reg == lepb_pkg::MODE_BLINK) ? lepb_pkg::BLINK_LAST_IDX
                                                         : lepb_pkg::RAMP_LAST_IDX;
    assign is_last  = (idx_reg == last_idx);
    assign free     = !valid_reg || (m_tready && is_last);
    assign load     = free && in_valid && !in_data.ctx.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else if (free)
        begin
            valid_reg <= load;
            idx_reg   <= 3'd0;
        end
        else if (m_tready)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // Program fields
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_reg  <= in_data.ctx.mode;
            level_reg <= in_data.ctx.level;
            word1_reg <= word1_next;
            word3_reg <= word3_next;
        end
    end

    // Word select by position
    always_comb
    begin
        case (idx_reg)
            3'd0:    word = lepb_pkg::WORD_SET_LEVEL | {8'h00, level_reg};
            3'd1:    word = word1_reg;
            3'd2:    word = (mode_reg == lepb_pkg::MODE_BLINK) ? lepb_pkg::WORD_SET_LEVEL
                                                               : lepb_pkg::WORD_LOOP;
            3'd3:    word = word3_reg;
            3'd4:    word = lepb_pkg::WORD_GO_START;
            default: word = lepb_pkg::WORD_GO_START;
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, idx_reg, word};
    assign m_tlast  = is_last;

endmodule

>>> rtl/lepb_checker.sv
// ============================================================================
// lepb_checker : port-level checks for the program builder
// Watches the output channel for word ordering and program framing.
// ============================================================================
module lepb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast
);

    // Stalled output beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // A non-final word is followed at once by the next position
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[18:16] == 3'($past(m_tdata[18:16]) + 3'd1)))
        else $error("program words out of sequence");

    // Programs end on word 3 or word 4
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[18:16] == 3'd3) || (m_tdata[18:16] == 3'd4))
        else $error("program ends at wrong position");

    // Every program opens with a set-level word
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[18:16] == 3'd0) |-> (m_tdata[15:8] == 8'h40))
        else $error("first word is not set-level");

    // Padding bits stay clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:19] == 5'd0))
        else $error("pad bits set on output");

endmodule

bind led_engine_program_builder lepb_checker u_lepb_checker (.*);

>>> bench/program_word_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// program_word_checker : request predictor and program word scoreboard
// Watches both stream channels of the program builder. Every accepted
// request is turned into the words of its engine program; every word beat
// leaving the block is compared field by field with the oldest one waiting.
// ============================================================================
module program_word_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          words_outstanding
);

    localparam logic [15:0] DELAY_LIMIT = 16'd63;
    localparam logic [15:0] RAMP_DOWN   = 16'h0080;
    localparam logic [15:0] HALF_BITS   = 16'h007F;

    typedef struct {
        logic [15:0] word;
        logic [2:0]  index;
        logic        final_word;
    } prog_word_t;

    prog_word_t expected_words[$];

    // Timing field of a delay or ramp word: cut to 16 bits, prescale above
    // the limit, then clamp to 1..63
    function automatic logic [15:0] timing_bits(input logic [16:0] raw);
        logic [15:0] ticks;
        logic        prescale;
        ticks    = raw[15:0];
        prescale = 1'b0;
        if (ticks > DELAY_LIMIT)
        begin
            ticks    = ticks / 16'd32;
            prescale = 1'b1;
        end
        if (ticks == 16'd0)
            ticks = 16'd1;
        else if (ticks > DELAY_LIMIT)
            ticks = DELAY_LIMIT;
        return {1'b0, prescale, ticks[5:0], 8'h00};
    endfunction

    task automatic push_word(input logic [15:0] w, input int pos, input int count);
        prog_word_t pw;
        pw.word       = w;
        pw.index      = pos[2:0];
        pw.final_word = (pos == count - 1);
        expected_words.push_back(pw);
    endtask

    // Words of the program that one request builds
    task automatic predict_program(input logic kind, input logic [71:0] req);
        logic [7:0]  lvl_from;
        logic [7:0]  lvl_to;
        logic [7:0]  span;
        logic [16:0] ramp_steps;
        logic [15:0] on_ticks;
        logic [15:0] off_ticks;
        logic [15:0] ramp_word;
        lvl_from  = req[7:0];
        lvl_to    = req[15:8];
        on_ticks  = req[47:32];
        off_ticks = req[63:48] - req[47:32];
        if (kind == lepb_pkg::MODE_RAMP)
        begin
            if (lvl_from != lvl_to)
            begin
                span       = (lvl_to > lvl_from) ? lvl_to - lvl_from : lvl_from - lvl_to;
                ramp_steps = {req[31:16], 1'b0} / {9'd0, span};
                ramp_word  = timing_bits(ramp_steps) | ({8'd0, span >> 1} & HALF_BITS);
                if (lvl_to < lvl_from)
                    ramp_word = ramp_word | RAMP_DOWN;
                push_word(lepb_pkg::WORD_SET_LEVEL | {8'd0, lvl_from}, 0, 4);
                push_word(ramp_word, 1, 4);
                push_word(lepb_pkg::WORD_LOOP, 2, 4);
                push_word(lepb_pkg::WORD_END, 3, 4);
            end
        end
        else
        begin
            push_word(lepb_pkg::WORD_SET_LEVEL | {8'd0, req[71:64]}, 0, 5);
            push_word(timing_bits({on_ticks, 1'b0}), 1, 5);
            push_word(lepb_pkg::WORD_SET_LEVEL, 2, 5);
            push_word(timing_bits({off_ticks, 1'b0}), 3, 5);
            push_word(lepb_pkg::WORD_GO_START, 4, 5);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Requests in, words out; requests are predicted before the word beat
    // of the same edge is checked
    always @(posedge clk or negedge rst_n)
    begin
        prog_word_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            words_outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_program(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word beat", m_tdata[15:0], 0);
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tdata[15:0] != want.word)
                        report_mismatch("program_word", m_tdata[15:0], want.word);
                    if (m_tdata[18:16] != want.index)
                        report_mismatch("word_index", m_tdata[18:16], want.index);
                    if (m_tlast != want.final_word)
                        report_mismatch("last", m_tlast, want.final_word);
                end
            end
            words_outstanding <= expected_words.size();
        end
    end

    initial
    begin
        mismatches = 0;
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb : testbench for the LED engine program builder
// Sends directed corner requests and then random ramp and blink requests
// under three idling mixes and one long receiver hold-off; the checker
// beside the block predicts and compares every program word.
// ============================================================================
module tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;     // [7:0] start_level, [15:8] end_level, [31:16] ramp_time,
                              // [47:32] on_duration, [63:48] blink_period, [71:64] blink_level
    logic [0:0]  s_tuser;     // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // [15:0] program_word, [18:16] word_index, zero pad
    logic        m_tlast;

    int mismatches;
    int words_outstanding;
    int tx_gap_pct;
    int rx_gap_pct;
    int hold_token;

    led_engine_program_builder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    program_word_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .mismatches        (mismatches),
        .words_outstanding (words_outstanding)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Word receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_gap_pct);
        end
    end

    // One request beat: random gaps first, then hold it until taken
    task automatic send_request(input logic kind, input logic [71:0] req);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 72'({$urandom, $urandom, $urandom});
            s_tuser  <= 1'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Unused fields of each kind carry noise
    task automatic ramp_request(input logic [7:0] lvl_from, input logic [7:0] lvl_to,
                                input logic [15:0] duration);
        logic [31:0] noise;
        logic [7:0]  noise_lvl;
        noise     = $urandom;
        noise_lvl = 8'($urandom);
        send_request(lepb_pkg::MODE_RAMP, {noise_lvl, noise, duration, lvl_to, lvl_from});
    endtask

    task automatic blink_request(input logic [15:0] on_time, input logic [15:0] period,
                                 input logic [7:0] lvl);
        logic [31:0] noise;
        noise = $urandom;
        send_request(lepb_pkg::MODE_BLINK, {lvl, period, on_time, noise});
    endtask

    // Durations clustered around the prescale and clamp thresholds
    function automatic logic [15:0] pick_duration();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(0, 40));
            1:       return 16'($urandom_range(0, 1100));
            2:       return 16'($urandom_range(32700, 32800));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_request();
        logic [7:0]  lvl_from;
        logic [7:0]  lvl_to;
        logic [15:0] on_time;
        logic [15:0] period;
        if ($urandom_range(1) == 0)
        begin
            lvl_from = 8'($urandom);
            lvl_to   = ($urandom_range(9) == 0) ? lvl_from : 8'($urandom);
            if ($urandom_range(3) == 0)
                lvl_to = lvl_from + 8'($urandom_range(1, 3));
            ramp_request(lvl_from, lvl_to, pick_duration());
        end
        else
        begin
            on_time = pick_duration();
            if ($urandom_range(2) == 0)
                period = 16'($urandom);
            else
                period = on_time + pick_duration();
            blink_request(on_time, period, 8'($urandom));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int waited;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        tx_gap_pct = 24;
        rx_gap_pct = 80;
        hold_token = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corners: extreme levels, equal levels, truncation of the
        // step value, prescale and clamp edges, wrapped blink off time
        ramp_request(8'd0, 8'd255, 16'd0);
        ramp_request(8'd255, 8'd0, 16'hFFFF);
        ramp_request(8'd0, 8'd0, 16'd100);
        ramp_request(8'd255, 8'd255, 16'hFFFF);
        ramp_request(8'd77, 8'd77, 16'd0);
        ramp_request(8'd10, 8'd11, 16'hFFFF);
        ramp_request(8'd10, 8'd11, 16'd32768);
        ramp_request(8'd20, 8'd22, 16'd63);
        ramp_request(8'd22, 8'd20, 16'd64);
        ramp_request(8'd0, 8'd1, 16'd31);
        ramp_request(8'd1, 8'd0, 16'd1015);
        ramp_request(8'd0, 8'd1, 16'd1016);
        ramp_request(8'd128, 8'd0, 16'd5000);
        blink_request(16'd0, 16'd0, 8'd0);
        blink_request(16'hFFFF, 16'hFFFF, 8'd255);
        blink_request(16'd32768, 16'd0, 8'd1);
        blink_request(16'd100, 16'd50, 8'd128);
        blink_request(16'd0, 16'hFFFF, 8'd200);
        blink_request(16'd31, 16'd63, 8'd15);
        blink_request(16'd32, 16'd1040, 8'd240);

        // Sender idles little, receiver much
        repeat (165) random_request();

        // Roles swapped
        tx_gap_pct = 80;
        rx_gap_pct = 24;
        repeat (165) random_request();

        // No idling; long receiver hold-off while requests keep coming
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        hold_token = hold_token + 1;
        repeat (170) random_request();
        s_tvalid <= 1'b0;

        // Drain, then let the divider chain empty
        waited = 0;
        while (words_outstanding != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);

        if (mismatches == 0 && words_outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
